// ===== design/slpi_pkg.sv =====
// Shared types and constants for the sounding log-pressure interpolator.
package slpi_pkg;

  localparam int PRESS_W        = 14;
  localparam int VAL_W          = 24;
  localparam int FLAG_W         = 5;
  localparam int NUM_QTY        = 4;
  localparam int COUNT_W        = 7;
  localparam int IDX_W          = 6;
  localparam int SEL_W          = 2;
  localparam int MAG_W          = 25;
  localparam int LOG_INT_W      = 4;
  localparam int MAX_LEVELS_DEF = 64;
  localparam int LOG_FRAC_DEF   = 16;

  localparam logic       MODE_LOAD  = 1'b0;
  localparam logic       MODE_QUERY = 1'b1;
  localparam logic [FLAG_W-1:0] FLAG_PRESSURE = 5'b00001;
  localparam logic [FLAG_W-1:0] FLAG_QTY_BASE = 5'b00010;
  localparam logic signed [25:0] RES_MAX = 26'sd8388607;
  localparam logic signed [25:0] RES_MIN = -26'sd8388607;

  typedef struct packed {
    logic                    mode;
    logic [IDX_W-1:0]        level_index;
    logic [PRESS_W-1:0]      pressure;
    logic signed [VAL_W-1:0] temperature_in;
    logic signed [VAL_W-1:0] dewpoint_in;
    logic signed [VAL_W-1:0] height_in;
    logic signed [VAL_W-1:0] omega_in;
    logic [FLAG_W-1:0]       valid_mask;
    logic [SEL_W-1:0]        quantity;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    found;
  } out_t;

  typedef struct packed {
    logic [PRESS_W-1:0]                pressure;
    logic [FLAG_W-1:0]                 flags;
    logic [NUM_QTY-1:0][VAL_W-1:0]     qty;
  } lvl_t;

endpackage

// ===== design/sounding_log_pressure_interpolator_unit.sv =====
// Top level of the sounding log-pressure interpolator.
//
// Input items arrive on in_valid/in_stall/in_data. A load item (mode 0) writes
// one sounding level into the level memory in the cycle it transfers and gives
// no result. A query item (mode 1) scans the levels from the surface upward for
// an exact or lower-pressure level, then downward for the bracketing level, and
// interpolates in log2 pressure; it gives one result on out_valid/out_stall/
// out_data. The level_count register is written on cfg_valid/cfg_data.
// Each level visited in either scan costs one memory read and one check; the
// scans are followed by three serial logarithms and a bit-serial divide.
// Most of a query's time goes to the scans over the single-port level memory
// and to the log unit.
// One query is worked on at a time; in_stall is high while it runs.
// Reset clears level_count and the control state; level memory contents are
// undefined until loaded. A finished result waits in the output register while
// out_stall is high, and new items may still transfer in the meantime.
module sounding_log_pressure_interpolator_unit #(
  parameter int MAX_LEVELS        = slpi_pkg::MAX_LEVELS_DEF,
  parameter int LOG_FRACTION_BITS = slpi_pkg::LOG_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  slpi_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output slpi_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slpi_pkg::COUNT_W-1:0]  cfg_data
);

  localparam int AW     = $clog2(MAX_LEVELS);
  localparam int CNT_W  = $clog2(MAX_LEVELS + 1);
  localparam int LW     = slpi_pkg::LOG_INT_W + LOG_FRACTION_BITS;
  localparam int PROD_W = LW + slpi_pkg::MAG_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = LW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CHK, S_DN_RD, S_DN_CHK, S_LOG_GO, S_LOG_WAIT,
    S_CALC, S_MUL, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  state_t                            state_r;
  logic [slpi_pkg::COUNT_W-1:0]      count_r;
  logic [CNT_W-1:0]                  n_r;
  logic [CNT_W-1:0]                  n_c;
  logic [CNT_W-1:0]                  i_r;
  logic [CNT_W-1:0]                  j_r;
  logic [slpi_pkg::PRESS_W-1:0]      q_r;
  logic [slpi_pkg::SEL_W-1:0]        sel_r;
  logic [slpi_pkg::FLAG_W-1:0]       need_r;
  logic [AW-1:0]                     above_r;
  logic [slpi_pkg::PRESS_W-1:0]      pa_r;
  logic [slpi_pkg::PRESS_W-1:0]      pb_r;
  logic signed [slpi_pkg::VAL_W-1:0] va_r;
  logic signed [slpi_pkg::VAL_W-1:0] vb_r;
  logic [1:0]                        lsel_r;
  logic [LW-1:0]                     lb_r;
  logic [LW-1:0]                     la_r;
  logic [LW-1:0]                     lq_r;
  logic [LW-1:0]                     d2_r;
  logic [LW-1:0]                     d4_r;
  logic                              neg_r;
  logic [slpi_pkg::MAG_W-1:0]        mag_r;
  logic [PROD_W-1:0]                 prod_r;
  logic signed [25:0]                res_r;
  logic                              found_r;
  logic                              out_valid_r;
  slpi_pkg::out_t                    out_data_r;

  logic                              mem_wr;
  logic                              mem_rd;
  logic [AW-1:0]                     mem_addr;
  slpi_pkg::lvl_t                    mem_wdata;
  slpi_pkg::lvl_t                    ent;
  logic                              usable_c;
  logic signed [slpi_pkg::VAL_W-1:0] val_c;

  logic                              log_start;
  logic [slpi_pkg::PRESS_W-1:0]      log_p;
  logic                              log_busy;
  logic                              log_done;
  logic [LW-1:0]                     log_res;

  logic                              div_start;
  logic [NUM_W-1:0]                  div_num;
  logic [DEN_W-1:0]                  div_den;
  logic                              div_done;
  logic [NUM_W-1:0]                  div_quo;

  logic [LW-1:0]                     d2_c;
  logic [LW-1:0]                     d4raw_c;
  logic signed [slpi_pkg::MAG_W-1:0] diff_c;
  logic signed [25:0]                vb_ext;
  logic signed [25:0]                qv_ext;
  logic signed [slpi_pkg::VAL_W-1:0] sat_c;
  logic                              accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Levels beyond the memory depth are never scanned.
  always_comb begin
    if (32'(count_r) > MAX_LEVELS) begin
      n_c = CNT_W'(MAX_LEVELS);
    end else begin
      n_c = CNT_W'(count_r);
    end
  end

  assign mem_wr = accept && (in_data.mode == slpi_pkg::MODE_LOAD) &&
                  (32'(in_data.level_index) < MAX_LEVELS);
  assign mem_rd = (state_r == S_UP_RD) || (state_r == S_DN_RD);

  always_comb begin
    if (state_r == S_DN_RD) begin
      mem_addr = AW'(j_r - 1'b1);
    end else if (state_r == S_UP_RD) begin
      mem_addr = i_r[AW-1:0];
    end else begin
      mem_addr = AW'(in_data.level_index);
    end
  end

  always_comb begin
    mem_wdata.pressure = in_data.pressure;
    mem_wdata.flags    = in_data.valid_mask;
    mem_wdata.qty[0]   = in_data.temperature_in;
    mem_wdata.qty[1]   = in_data.dewpoint_in;
    mem_wdata.qty[2]   = in_data.height_in;
    mem_wdata.qty[3]   = in_data.omega_in;
  end

  slpi_store #(.MAX_LEVELS(MAX_LEVELS)) u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .rd_en   (mem_rd),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (ent)
  );

  assign usable_c = ((ent.flags & need_r) == need_r) && (ent.pressure != '0);
  assign val_c    = $signed(ent.qty[sel_r]);

  assign log_start = (state_r == S_LOG_GO);
  always_comb begin
    case (lsel_r)
      2'd0:    log_p = pb_r;
      2'd1:    log_p = pa_r;
      default: log_p = q_r;
    endcase
  end

  slpi_log2 #(.FRAC_BITS(LOG_FRACTION_BITS)) u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .p      (log_p),
    .busy   (log_busy),
    .done   (log_done),
    .result (log_res)
  );

  assign div_start = (state_r == S_DIV_GO);
  assign div_num   = {prod_r, 1'b0} + NUM_W'(d2_r);
  assign div_den   = {d2_r, 1'b0};

  slpi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign d2_c    = (lb_r > la_r) ? LW'(lb_r - la_r) : '0;
  assign d4raw_c = (lb_r > lq_r) ? LW'(lb_r - lq_r) : '0;
  assign diff_c  = {va_r[slpi_pkg::VAL_W-1], va_r} - {vb_r[slpi_pkg::VAL_W-1], vb_r};
  assign vb_ext  = {{2{vb_r[slpi_pkg::VAL_W-1]}}, vb_r};
  assign qv_ext  = $signed({1'b0, div_quo[slpi_pkg::MAG_W-1:0]});

  always_comb begin
    if (res_r > slpi_pkg::RES_MAX) begin
      sat_c = slpi_pkg::RES_MAX[slpi_pkg::VAL_W-1:0];
    end else if (res_r < slpi_pkg::RES_MIN) begin
      sat_c = slpi_pkg::RES_MIN[slpi_pkg::VAL_W-1:0];
    end else begin
      sat_c = res_r[slpi_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      lsel_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
      // In S_OUT a transfer of the old result is followed by the new one below.
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && (in_data.mode == slpi_pkg::MODE_QUERY)) begin
            q_r     <= in_data.pressure;
            sel_r   <= in_data.quantity;
            need_r  <= slpi_pkg::FLAG_PRESSURE |
                       (slpi_pkg::FLAG_QTY_BASE << in_data.quantity);
            n_r     <= n_c;
            i_r     <= '0;
            j_r     <= n_c;
            found_r <= 1'b0;
            res_r   <= '0;
            state_r <= (n_c == '0) ? S_OUT : S_UP_RD;
          end
        end
        S_UP_RD: begin
          state_r <= S_UP_CHK;
        end
        S_UP_CHK: begin
          if (usable_c && (ent.pressure == q_r)) begin
            res_r   <= {{2{val_c[slpi_pkg::VAL_W-1]}}, val_c};
            found_r <= 1'b1;
            state_r <= S_OUT;
          end else if (usable_c && (ent.pressure < q_r)) begin
            above_r <= i_r[AW-1:0];
            pa_r    <= ent.pressure;
            va_r    <= val_c;
            state_r <= S_DN_RD;
          end else if (CNT_W'(i_r + 1'b1) == n_r) begin
            state_r <= S_OUT;
          end else begin
            i_r     <= CNT_W'(i_r + 1'b1);
            state_r <= S_UP_RD;
          end
        end
        S_DN_RD: begin
          state_r <= S_DN_CHK;
        end
        S_DN_CHK: begin
          if (usable_c && (ent.pressure >= q_r)) begin
            pb_r    <= ent.pressure;
            vb_r    <= val_c;
            found_r <= 1'b1;
            if (AW'(j_r - 1'b1) == above_r) begin
              res_r   <= {{2{va_r[slpi_pkg::VAL_W-1]}}, va_r};
              state_r <= S_OUT;
            end else begin
              lsel_r  <= '0;
              state_r <= S_LOG_GO;
            end
          end else if (j_r == CNT_W'(1)) begin
            state_r <= S_OUT;
          end else begin
            j_r     <= CNT_W'(j_r - 1'b1);
            state_r <= S_DN_RD;
          end
        end
        S_LOG_GO: begin
          state_r <= S_LOG_WAIT;
        end
        S_LOG_WAIT: begin
          if (log_done) begin
            case (lsel_r)
              2'd0:    lb_r <= log_res;
              2'd1:    la_r <= log_res;
              default: lq_r <= log_res;
            endcase
            if (lsel_r == 2'd2) begin
              state_r <= S_CALC;
            end else begin
              lsel_r  <= lsel_r + 2'd1;
              state_r <= S_LOG_GO;
            end
          end
        end
        S_CALC: begin
          d2_r  <= d2_c;
          d4_r  <= (d4raw_c > d2_c) ? d2_c : d4raw_c;
          neg_r <= diff_c < 0;
          mag_r <= (diff_c < 0) ? slpi_pkg::MAG_W'(-diff_c) : slpi_pkg::MAG_W'(diff_c);
          if (d2_c == '0) begin
            res_r   <= vb_ext;
            state_r <= S_OUT;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(d4_r * mag_r);
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res_r   <= neg_r ? 26'(vb_ext - qv_ext) : 26'(vb_ext + qv_ext);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r      <= 1'b1;
            out_data_r.value <= found_r ? sat_c : '0;
            out_data_r.found <= found_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A missing bracket always reports a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.found |-> out_data_r.value == '0)
    else $error("result without bracket carries a nonzero value");

  // Saturation keeps the most negative code off the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.value != 24'h800000)
    else $error("result value not saturated");

  // The rounded quotient never exceeds the quantity difference.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_quo <= NUM_W'(mag_r))
    else $error("interpolation quotient out of range");

  // The log unit is only started when it is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    log_start |-> !log_busy)
    else $error("log unit restarted while busy");

  // A transferred query always leaves the idle state.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.mode == slpi_pkg::MODE_QUERY) |=> state_r != S_IDLE)
    else $error("query transfer did not start a search");

endmodule

// ===== design/slpi_store.sv =====
// Level memory: one entry per sounding level, a single address port for writes and registered reads.
module slpi_store #(
  parameter int MAX_LEVELS = slpi_pkg::MAX_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic                              rd_en,
  input  logic [$clog2(MAX_LEVELS)-1:0]     addr,
  input  slpi_pkg::lvl_t                    wr_data,
  output slpi_pkg::lvl_t                    rd_data
);

  slpi_pkg::lvl_t mem_r [MAX_LEVELS];
  slpi_pkg::lvl_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/slpi_log2.sv =====
// Iterative fixed-point log2 of a pressure by repeated squaring, one fraction bit per cycle.
module slpi_log2 #(
  parameter int FRAC_BITS = slpi_pkg::LOG_FRAC_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic [slpi_pkg::PRESS_W-1:0]             p,
  output logic                                     busy,
  output logic                                     done,
  output logic [slpi_pkg::LOG_INT_W+FRAC_BITS-1:0] result
);

  localparam int KW = $clog2(FRAC_BITS + 1);

  logic                              busy_r;
  logic                              done_r;
  logic [KW-1:0]                     k_r;
  logic [30:0]                       y_r;
  logic [FRAC_BITS-1:0]              frac_r;
  logic [slpi_pkg::LOG_INT_W-1:0]    m_r;
  logic [slpi_pkg::LOG_INT_W-1:0]    m_c;
  logic [30:0]                       p_ext;
  logic [30:0]                       y_init;
  logic [61:0]                       sq;
  logic [31:0]                       sqs;
  logic [30:0]                       y_nxt;

  always_comb begin
    m_c = '0;
    for (int b = 1; b < slpi_pkg::PRESS_W; b++) begin
      if (p[b]) begin
        m_c = slpi_pkg::LOG_INT_W'(b);
      end
    end
  end

  assign p_ext  = {{(31 - slpi_pkg::PRESS_W){1'b0}}, p};
  assign y_init = p_ext << (5'd30 - {1'b0, m_c});
  assign sq     = y_r * y_r;
  assign sqs    = sq[61:30];
  assign y_nxt  = sqs[31] ? sqs[31:1] : sqs[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= KW'(k_r + 1'b1);
        if (k_r == KW'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y_r <= y_init;
      m_r <= m_c;
    end else if (busy_r) begin
      y_r    <= y_nxt;
      frac_r <= {frac_r[FRAC_BITS-2:0], sqs[31]};
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = {m_r, frac_r};

endmodule

// ===== design/slpi_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module slpi_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== tb/sv/slpi_checker.sv =====
// Checker for the sounding interpolator: predicts each query result and compares.
module slpi_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  slpi_pkg::in_t                in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  slpi_pkg::out_t               out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [slpi_pkg::COUNT_W-1:0] cfg_data,
  output int                           mismatches,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = slpi_pkg::MAX_LEVELS_DEF;
  localparam int FRAC = slpi_pkg::LOG_FRAC_DEF;

  logic [slpi_pkg::PRESS_W-1:0]      shadow_press [LEVELS];
  logic [slpi_pkg::FLAG_W-1:0]       shadow_flags [LEVELS];
  logic signed [slpi_pkg::VAL_W-1:0] shadow_qty   [LEVELS][slpi_pkg::NUM_QTY];
  logic [slpi_pkg::COUNT_W-1:0]      shadow_count;
  slpi_pkg::out_t                    awaited_results [$];

  assign pending = awaited_results.size();

  function automatic longint unsigned log2_q16(input logic [slpi_pkg::PRESS_W-1:0] p);
    int top_bit;
    longint unsigned y, frac;
    top_bit = 0;
    frac = 0;
    for (int b = 0; b < slpi_pkg::PRESS_W; b++) if (p[b]) top_bit = b;
    y = longint'(p) << (30 - top_bit);
    for (int k = 0; k < FRAC; k++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        frac = frac | 1;
        y = y >> 1;
      end
    end
    return (longint'(top_bit) << FRAC) | frac;
  endfunction

  function automatic bit level_ok(input int i, input logic [slpi_pkg::FLAG_W-1:0] need);
    return ((shadow_flags[i] & need) == need) && (shadow_press[i] != 0);
  endfunction

  function automatic slpi_pkg::out_t interpolate_query(
      input logic [slpi_pkg::PRESS_W-1:0] q, input logic [slpi_pkg::SEL_W-1:0] sel);
    logic [slpi_pkg::FLAG_W-1:0] need;
    int n, above, below;
    bit has_above, has_below, hit;
    longint acc, va, vb, diff;
    longint unsigned lb, la, lq, d2, d4, mag, quo;
    slpi_pkg::out_t r;
    need = slpi_pkg::FLAG_PRESSURE | (slpi_pkg::FLAG_QTY_BASE << sel);
    n = (shadow_count > LEVELS) ? LEVELS : int'(shadow_count);
    has_above = 0;
    has_below = 0;
    hit = 0;
    above = 0;
    below = 0;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      if (!level_ok(i, need)) continue;
      if (shadow_press[i] == q) begin
        acc = shadow_qty[i][sel];
        hit = 1;
        break;
      end
      if (shadow_press[i] < q) begin
        above = i;
        has_above = 1;
        break;
      end
    end
    if (!hit && has_above) begin
      for (int i = n - 1; i >= 0; i--) begin
        if (level_ok(i, need) && shadow_press[i] >= q) begin
          below = i;
          has_below = 1;
          break;
        end
      end
      if (has_below) begin
        va = shadow_qty[above][sel];
        vb = shadow_qty[below][sel];
        hit = 1;
        if (above == below) begin
          acc = va;
        end else begin
          lb = log2_q16(shadow_press[below]);
          la = log2_q16(shadow_press[above]);
          lq = log2_q16(q);
          d2 = (lb > la) ? lb - la : 0;
          d4 = (lb > lq) ? lb - lq : 0;
          if (d2 == 0) begin
            acc = vb;
          end else begin
            diff = va - vb;
            mag = (diff < 0) ? -diff : diff;
            if (d4 > d2) d4 = d2;
            quo = (2 * d4 * mag + d2) / (2 * d2);
            acc = (diff < 0) ? vb - longint'(quo) : vb + longint'(quo);
          end
        end
      end
    end
    if (!hit) acc = 0;
    else if (acc > 8388607) acc = 8388607;
    else if (acc < -8388607) acc = -8388607;
    r.value = acc[slpi_pkg::VAL_W-1:0];
    r.found = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    slpi_pkg::out_t want;
    if (!rst_n) begin
      shadow_count <= '0;
      mismatches <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result value=%0d found=%0b", $realtime,
                     out_data.value, out_data.found);
          mismatches <= mismatches + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want.value !== out_data.value || want.found !== out_data.found) begin
            if (mismatches < 10)
              $display("%0t: expected value=%0d found=%0b, got value=%0d found=%0b",
                       $realtime, want.value, want.found, out_data.value, out_data.found);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.mode == slpi_pkg::MODE_LOAD) begin
          shadow_press[in_data.level_index] <= in_data.pressure;
          shadow_flags[in_data.level_index] <= in_data.valid_mask;
          shadow_qty[in_data.level_index][0] <= in_data.temperature_in;
          shadow_qty[in_data.level_index][1] <= in_data.dewpoint_in;
          shadow_qty[in_data.level_index][2] <= in_data.height_in;
          shadow_qty[in_data.level_index][3] <= in_data.omega_in;
        end else begin
          awaited_results.push_back(interpolate_query(in_data.pressure, in_data.quantity));
        end
      end
      if (cfg_valid && cfg_ready) shadow_count <= cfg_data;
    end
  end
endmodule

// ===== tb/sv/sounding_log_pressure_interpolator_unit_tb.sv =====
// Testbench top: drives loads, queries and level_count writes, and gives the verdict.
module sounding_log_pressure_interpolator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  slpi_pkg::in_t in_data;
  slpi_pkg::out_t out_data;
  logic [slpi_pkg::COUNT_W-1:0] cfg_data;
  int mismatches, pending;
  bit calm;
  logic [slpi_pkg::PRESS_W-1:0] loaded_press [slpi_pkg::MAX_LEVELS_DEF];

  sounding_log_pressure_interpolator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  slpi_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [slpi_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800001;
      2: return 24'h800000;
      default: return slpi_pkg::VAL_W'($urandom());
    endcase
  endfunction

  // Send one item; gap of zero keeps valid high into the next transfer.
  task automatic send_item(input slpi_pkg::in_t item);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_data = item;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic load_level(input int idx, input logic [slpi_pkg::PRESS_W-1:0] p,
                            input logic [slpi_pkg::FLAG_W-1:0] mask);
    slpi_pkg::in_t item;
    item.mode = slpi_pkg::MODE_LOAD;
    item.level_index = slpi_pkg::IDX_W'(idx);
    item.pressure = p;
    item.temperature_in = rand_value();
    item.dewpoint_in = rand_value();
    item.height_in = rand_value();
    item.omega_in = rand_value();
    item.valid_mask = mask;
    item.quantity = slpi_pkg::SEL_W'($urandom());
    loaded_press[idx] = p;
    send_item(item);
  endtask

  task automatic query(input logic [slpi_pkg::PRESS_W-1:0] p,
                       input logic [slpi_pkg::SEL_W-1:0] sel);
    slpi_pkg::in_t item;
    logic [127:0] noise;
    noise = {$urandom(), $urandom(), $urandom(), $urandom()};
    item = noise[$bits(slpi_pkg::in_t)-1:0];
    item.mode = slpi_pkg::MODE_QUERY;
    item.pressure = p;
    item.quantity = sel;
    send_item(item);
  endtask

  // Writes to level_count wait until the block has drained.
  task automatic write_count(input int n);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_data = slpi_pkg::COUNT_W'(n);
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // A mostly well-formed sounding: pressure falls from the surface upward.
  task automatic load_sounding(input int n);
    int p;
    p = $urandom_range(9000, 11000);
    for (int i = 0; i < n; i++) begin
      load_level(i, (($urandom_range(0, 15) == 0) ? slpi_pkg::PRESS_W'($urandom())
                                                  : slpi_pkg::PRESS_W'(p)),
                 (($urandom_range(0, 5) == 0) ? slpi_pkg::FLAG_W'($urandom()) : 5'h1F));
      p = p - $urandom_range(1, 400);
      if (p < 1) p = $urandom_range(1, 3);
    end
  endtask

  function automatic logic [slpi_pkg::PRESS_W-1:0] query_pressure(input int n);
    case ($urandom_range(0, 9))
      0: return slpi_pkg::PRESS_W'($urandom());
      1: return loaded_press[$urandom_range(0, (n > 0) ? n - 1 : 0)];
      2: return 0;
      default: return slpi_pkg::PRESS_W'($urandom_range(1, 11000));
    endcase
  endfunction

  initial begin
    int n;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_data = '0;
    calm = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;

    // Every slot is written before any query can scan it.
    for (int i = 0; i < slpi_pkg::MAX_LEVELS_DEF; i++)
      load_level(i, slpi_pkg::PRESS_W'($urandom()), slpi_pkg::FLAG_W'($urandom()));

    // Directed: empty count, then a small hand-built sounding.
    query(5000, 0);
    write_count(4);
    load_level(0, 11000, 5'h1F);
    load_level(1, 8500, 5'h1D);
    load_level(2, 5000, 5'h1F);
    load_level(3, 1, 5'h1F);
    for (int s = 0; s < slpi_pkg::NUM_QTY; s++) query(7000, slpi_pkg::SEL_W'(s));
    query(11000, 2);
    query(5000, 3);
    query(1, 0);
    query(0, 1);
    query(16383, 0);
    query(2, 1);
    query(8500, 1);
    load_level(1, 0, 5'h1F);
    query(9000, 0);
    write_count(127);
    query(3000, 2);
    write_count(1);
    query(3000, 2);
    query(11000, 3);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 5)
        0: n = 64;
        1: n = 2;
        2: n = $urandom_range(65, 127);
        3: n = 0;
        default: n = $urandom_range(1, 64);
      endcase
      calm = (phase % 4 == 3);
      write_count(n);
      load_sounding((n > 64) ? 64 : n);
      for (int k = 0; k < 20; k++) begin
        if ($urandom_range(0, 9) == 0)
          load_level($urandom_range(0, 63), slpi_pkg::PRESS_W'($urandom()),
                     slpi_pkg::FLAG_W'($urandom()));
        else
          query(query_pressure((n > 64) ? 64 : n), slpi_pkg::SEL_W'($urandom()));
      end
    end

    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side may hold stall before each transfer, at random; calm phases never stall.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = calm ? 0 : $urandom_range(0, 14);
      out_stall = (hold != 0);
      repeat (hold) @(negedge clk);
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
    end
  end
endmodule

// ===== sounding_log_pressure_interpolator_unit.f =====
design/slpi_pkg.sv
design/slpi_store.sv
design/slpi_log2.sv
design/slpi_div.sv
design/sounding_log_pressure_interpolator_unit.sv
tb/sv/slpi_checker.sv
tb/sv/sounding_log_pressure_interpolator_unit_tb.sv
